// ----- design/wtfs_pkg.sv -----
// Shared types, register codes and defaults for the weighted term frequency scorer.
// No dependencies; imported by every module of the block.
`default_nettype none

package wtfs_pkg;

  localparam int MAX_TERM_DEF   = 16;
  localparam int SCORE_BITS_DEF = 32;
  localparam int CFG_IDX_W      = 4;
  localparam int CFG_DATA_W     = 64;
  localparam int TERM_LEN_W     = 5;
  localparam int WEIGHT_W       = 8;
  localparam int CHAR_W         = 8;
  localparam int OUT_SCORE_W    = 32;

  localparam logic [TERM_LEN_W-1:0] TERM_LEN_RST     = 5'd1;
  localparam logic [WEIGHT_W-1:0]   W_TITLE_RST      = 8'd16;
  localparam logic [WEIGHT_W-1:0]   W_DOMAIN_RST     = 8'd8;
  localparam logic [WEIGHT_W-1:0]   W_KEYWORD_RST    = 8'd4;
  localparam logic [WEIGHT_W-1:0]   W_URL_RST        = 8'd2;
  localparam logic [WEIGHT_W-1:0]   W_TEXT_RST       = 8'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TERM_LO    = 4'd0,
    CFG_TERM_HI    = 4'd1,
    CFG_TERM_LEN   = 4'd2,
    CFG_W_TITLE    = 4'd3,
    CFG_W_DOMAIN   = 4'd4,
    CFG_W_KEYWORD  = 4'd5,
    CFG_W_URL      = 4'd6,
    CFG_W_TEXT     = 4'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_TITLE   = 2'd0,
    KIND_URL     = 2'd1,
    KIND_KEYWORD = 2'd2,
    KIND_TEXT    = 2'd3
  } field_kind_t;

  typedef struct packed {
    logic shift;
    logic restart;
  } cell_ctl_t;

  typedef struct packed {
    logic        valid;
    logic        hit;
    field_kind_t kind;
    logic        page_end;
  } score_item_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0] title;
    logic [WEIGHT_W-1:0] domain;
    logic [WEIGHT_W-1:0] keyword;
    logic [WEIGHT_W-1:0] url;
    logic [WEIGHT_W-1:0] text;
  } weights_t;

endpackage

`default_nettype wire

// ----- design/wtfs_cell.sv -----
// One cell of the prefix match chain: holds whether the term prefix ending at
// this cell's byte matched the newest bytes. Depends on wtfs_pkg.
`default_nettype none

module wtfs_cell
  import wtfs_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire cell_ctl_t         ctl,
  input  wire logic [CHAR_W-1:0] in_char,
  input  wire logic [CHAR_W-1:0] term_char,
  input  wire logic              prev_match,
  input  wire logic              last,
  output logic                   match_r,
  output logic                   hit
);

  logic match_nxt;

  assign match_nxt = prev_match & (in_char == term_char);
  assign hit       = match_nxt & last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else if (ctl.shift) begin
      match_r <= ctl.restart ? 1'b0 : match_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- design/wtfs_accum.sv -----
// Saturating score accumulator and output register.
// Depends on wtfs_pkg; fed by the match stage of the top level.
`default_nettype none

module wtfs_accum
  import wtfs_pkg::*;
#(
  parameter int SCORE_BITS = SCORE_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire score_item_t            item,
  input  wire weights_t               weights,
  input  wire logic                   out_ready,
  output logic                        hold,
  output logic                        out_valid,
  output logic [OUT_SCORE_W-1:0]      out_page_score,
  output logic                        out_score_saturated
);

  localparam logic [SCORE_BITS-1:0] SCORE_MAX = '1;

  logic [SCORE_BITS-1:0] total_r;
  logic [SCORE_BITS-1:0] total_nxt;
  logic [SCORE_BITS:0]   sum;
  logic [WEIGHT_W:0]     weight;
  logic [OUT_SCORE_W-1:0] score_out;
  logic                  go;
  logic                  out_valid_r;
  logic [OUT_SCORE_W-1:0] score_r;
  logic                  sat_r;

  always_comb begin
    unique case (item.kind)
      KIND_TITLE:   weight = {1'b0, weights.title};
      KIND_URL:     weight = {1'b0, weights.domain} + {1'b0, weights.url};
      KIND_KEYWORD: weight = {1'b0, weights.keyword};
      KIND_TEXT:    weight = {1'b0, weights.text};
    endcase
  end

  assign sum = {1'b0, total_r} + (SCORE_BITS+1)'(weight);

  always_comb begin
    total_nxt = total_r;
    if (item.hit) begin
      total_nxt = sum[SCORE_BITS] ? SCORE_MAX : sum[SCORE_BITS-1:0];
    end
  end

  generate
    if (SCORE_BITS >= OUT_SCORE_W) begin : g_trunc
      assign score_out = total_nxt[OUT_SCORE_W-1:0];
    end else begin : g_ext
      assign score_out = {{(OUT_SCORE_W-SCORE_BITS){1'b0}}, total_nxt};
    end
  endgenerate

  assign hold = item.valid & item.page_end & out_valid_r & ~out_ready;
  assign go   = item.valid & ~hold;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (go) begin
        total_r <= item.page_end ? '0 : total_nxt;
      end
      if (go && item.page_end) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && item.page_end) begin
      score_r <= score_out;
      sat_r   <= (total_nxt == SCORE_MAX);
    end
  end

  assign out_valid           = out_valid_r;
  assign out_page_score      = score_r;
  assign out_score_saturated = sat_r;

endmodule

`default_nettype wire

// ----- design/weighted_term_frequency_scorer.sv -----
// A page's score is registered once its page end item leaves the match stage.
// Throughput: one item per cycle; each byte is compared in every cell of the chain at once
// and its weight added after the match stage. in_ready drops only while a page end item
// waits behind a score that has not been taken.
// Reset: synchronous, active low; registers return to their defaults, score and chain clear.
// Depends on wtfs_pkg, wtfs_cell and wtfs_accum.
`default_nettype none

module weighted_term_frequency_scorer
  import wtfs_pkg::*;
#(
  parameter int MAX_TERM   = MAX_TERM_DEF,
  parameter int SCORE_BITS = SCORE_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [CHAR_W-1:0]      in_character,
  input  wire logic [1:0]             in_field_kind,
  input  wire logic                   in_string_end,
  input  wire logic                   in_page_end,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [OUT_SCORE_W-1:0]      out_page_score,
  output logic                        out_score_saturated,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int LW = $clog2(MAX_TERM + 1);
  localparam int CW = (LW > TERM_LEN_W) ? LW : TERM_LEN_W;
  localparam int BW = $clog2(MAX_TERM);

  logic [CFG_DATA_W-1:0] term_lo_r;
  logic [CFG_DATA_W-1:0] term_hi_r;
  logic [TERM_LEN_W-1:0] term_len_r;
  weights_t              weights_r;

  logic [CW-1:0]         len_ext;
  logic [CW-1:0]         len_c;
  logic [MAX_TERM:0]     chain;
  logic [MAX_TERM-1:0]   is_last;
  logic [MAX_TERM-1:0]   hit_vec;
  logic                  hit_gated;
  logic                  accept;
  logic                  hold;
  cell_ctl_t             cell_ctl;
  logic [BW-1:0]         block_r;
  logic [BW-1:0]         block_nxt;
  score_item_t           item_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_lo_r         <= '0;
      term_hi_r         <= '0;
      term_len_r        <= TERM_LEN_RST;
      weights_r.title   <= W_TITLE_RST;
      weights_r.domain  <= W_DOMAIN_RST;
      weights_r.keyword <= W_KEYWORD_RST;
      weights_r.url     <= W_URL_RST;
      weights_r.text    <= W_TEXT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_TERM_LO:   term_lo_r         <= cfg_data;
        CFG_TERM_HI:   term_hi_r         <= cfg_data;
        CFG_TERM_LEN:  term_len_r        <= cfg_data[TERM_LEN_W-1:0];
        CFG_W_TITLE:   weights_r.title   <= cfg_data[WEIGHT_W-1:0];
        CFG_W_DOMAIN:  weights_r.domain  <= cfg_data[WEIGHT_W-1:0];
        CFG_W_KEYWORD: weights_r.keyword <= cfg_data[WEIGHT_W-1:0];
        CFG_W_URL:     weights_r.url     <= cfg_data[WEIGHT_W-1:0];
        CFG_W_TEXT:    weights_r.text    <= cfg_data[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  assign len_ext = CW'(term_len_r);
  assign len_c   = (len_ext > CW'(MAX_TERM)) ? CW'(MAX_TERM) : len_ext;

  assign in_ready         = ~hold;
  assign accept           = in_valid & in_ready;
  assign cell_ctl.shift   = accept;
  assign cell_ctl.restart = in_string_end | in_page_end;
  assign chain[0]         = 1'b1;

  generate
    for (genvar k = 0; k < MAX_TERM; k++) begin : g_cell
      logic [CHAR_W-1:0] term_char;
      if (k < 8) begin : g_lo
        assign term_char = term_lo_r[8*k +: 8];
      end else if (k < 16) begin : g_hi
        assign term_char = term_hi_r[8*(k-8) +: 8];
      end else begin : g_zero
        assign term_char = '0;
      end
      assign is_last[k] = (len_c == CW'(k + 1));

      wtfs_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (cell_ctl),
        .in_char    (in_character),
        .term_char  (term_char),
        .prev_match (chain[k]),
        .last       (is_last[k]),
        .match_r    (chain[k+1]),
        .hit        (hit_vec[k])
      );
    end
  endgenerate

  assign hit_gated = (|hit_vec) & (block_r == '0);

  always_comb begin
    block_nxt = block_r;
    if (cell_ctl.restart) begin
      block_nxt = '0;
    end else if (block_r != '0) begin
      block_nxt = block_r - 1'b1;
    end else if (hit_gated) begin
      block_nxt = BW'(len_c - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_r <= '0;
      item_r  <= '0;
    end else begin
      if (accept) begin
        block_r <= block_nxt;
      end
      if (in_ready) begin
        item_r.valid    <= accept;
        item_r.hit      <= hit_gated;
        item_r.kind     <= field_kind_t'(in_field_kind);
        item_r.page_end <= in_page_end;
      end
    end
  end

  wtfs_accum #(
    .SCORE_BITS (SCORE_BITS)
  ) u_accum (
    .clk                 (clk),
    .rst_n               (rst_n),
    .item                (item_r),
    .weights             (weights_r),
    .out_ready           (out_ready),
    .hold                (hold),
    .out_valid           (out_valid),
    .out_page_score      (out_page_score),
    .out_score_saturated (out_score_saturated)
  );

endmodule

`default_nettype wire

// ----- design/wtfs_checker.sv -----
// Port level checks for the weighted term frequency scorer, bound to the top level.
// Depends on wtfs_pkg and weighted_term_frequency_scorer.
`default_nettype none

module wtfs_checker
  import wtfs_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_valid,
  input wire logic                   in_ready,
  input wire logic                   in_page_end,
  input wire logic                   out_valid,
  input wire logic                   out_ready,
  input wire logic [OUT_SCORE_W-1:0] out_page_score,
  input wire logic                   out_score_saturated,
  input wire logic                   cfg_valid,
  input wire logic                   cfg_ready
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_page_score)
      && $stable(out_score_saturated))
    else $error("Result item changed while stalled.");

  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("Input stalled without a waiting result item.");

  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_page_end, 2))
    else $error("Result item without a page end item two cycles earlier.");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("Configuration write not taken.");

endmodule

bind weighted_term_frequency_scorer wtfs_checker u_wtfs_checker (.*);

`default_nettype wire

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for weighted_term_frequency_scorer: drives byte items, register
// writes and random handshake gaps, predicts each page score and compares it on arrival.
// Depends on wtfs_pkg and the scorer RTL.

module tb;
  import wtfs_pkg::*;

  localparam int HALF_PERIOD = 1;
  localparam int SCORE_W = SCORE_BITS_DEF;
  localparam logic [SCORE_W-1:0] SCORE_MAX = '1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 4'hF;
  localparam int STIM_ITEMS = 1000;
  localparam int HOLD_CYCLES = 64;
  localparam int STALL_LIMIT = 2000;

  typedef struct {
    logic [OUT_SCORE_W-1:0] score;
    logic                   saturated;
  } score_rec_t;

  class page_score_tracker;
    logic [CFG_DATA_W-1:0] term_lo;
    logic [CFG_DATA_W-1:0] term_hi;
    logic [TERM_LEN_W-1:0] term_len;
    weights_t              wts;
    logic [CHAR_W-1:0]     window [MAX_TERM_DEF];
    logic [4:0]            fill;
    logic [3:0]            blocked;
    logic [SCORE_W-1:0]    total;
    logic                  saturated;
    score_rec_t            expected_scores [$];
    int                    errors;

    function new();
      term_lo = '0;
      term_hi = '0;
      term_len = TERM_LEN_RST;
      wts.title = W_TITLE_RST;
      wts.domain = W_DOMAIN_RST;
      wts.keyword = W_KEYWORD_RST;
      wts.url = W_URL_RST;
      wts.text = W_TEXT_RST;
      clear_string();
      total = '0;
      saturated = 1'b0;
      errors = 0;
    endfunction

    function void clear_string();
      foreach (window[i]) window[i] = '0;
      fill = '0;
      blocked = '0;
    endfunction

    function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_TERM_LO:   term_lo = data;
        CFG_TERM_HI:   term_hi = data;
        CFG_TERM_LEN:  term_len = data[TERM_LEN_W-1:0];
        CFG_W_TITLE:   wts.title = data[WEIGHT_W-1:0];
        CFG_W_DOMAIN:  wts.domain = data[WEIGHT_W-1:0];
        CFG_W_KEYWORD: wts.keyword = data[WEIGHT_W-1:0];
        CFG_W_URL:     wts.url = data[WEIGHT_W-1:0];
        CFG_W_TEXT:    wts.text = data[WEIGHT_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_byte(logic [CHAR_W-1:0] ch, field_kind_t kind, logic str_end,
                            logic pg_end);
      int len;
      bit hit;
      logic [WEIGHT_W:0] w;
      logic [SCORE_W:0] sum;
      logic [2*CFG_DATA_W-1:0] term;
      score_rec_t rec;
      len = (term_len > MAX_TERM_DEF) ? MAX_TERM_DEF : int'(term_len);
      for (int i = MAX_TERM_DEF - 1; i > 0; i--) window[i] = window[i-1];
      window[0] = ch;
      if (fill < MAX_TERM_DEF) fill++;
      if (blocked != 0) begin
        blocked--;
      end else if (len > 0 && fill >= len) begin
        term = {term_hi, term_lo};
        hit = 1'b1;
        for (int i = 0; i < len; i++) begin
          if (window[len-1-i] != term[8*i +: 8]) hit = 1'b0;
        end
        if (hit) begin
          case (kind)
            KIND_TITLE:   w = {1'b0, wts.title};
            KIND_URL:     w = {1'b0, wts.domain} + {1'b0, wts.url};
            KIND_KEYWORD: w = {1'b0, wts.keyword};
            default:      w = {1'b0, wts.text};
          endcase
          sum = total + w;
          if (sum > {1'b0, SCORE_MAX}) total = SCORE_MAX;
          else total = sum[SCORE_W-1:0];
          if (total == SCORE_MAX) saturated = 1'b1;
          blocked = 4'(len - 1);
        end
      end
      if (str_end || pg_end) clear_string();
      if (pg_end) begin
        rec.score = OUT_SCORE_W'(total);
        rec.saturated = saturated;
        expected_scores.insert(expected_scores.size(), rec);
        total = '0;
        saturated = 1'b0;
      end
    endfunction

    task report(string msg);
      errors++;
      $display("ERROR %0t: %s", $time, msg);
    endtask

    task check_score(logic [OUT_SCORE_W-1:0] score, logic sat);
      score_rec_t want;
      if (expected_scores.size() == 0) begin
        report($sformatf("page score %0d arrived with no page pending", score));
      end else begin
        want = expected_scores.pop_front();
        if (score !== want.score)
          report($sformatf("page_score %0d, expected %0d", score, want.score));
        if (sat !== want.saturated)
          report($sformatf("score_saturated %b, expected %b", sat, want.saturated));
      end
    endtask

    function int pending();
      return expected_scores.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [CHAR_W-1:0] in_character;
  logic [1:0] in_field_kind;
  logic in_string_end;
  logic in_page_end;
  logic out_valid;
  logic out_ready;
  logic [OUT_SCORE_W-1:0] out_page_score;
  logic out_score_saturated;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  page_score_tracker tracker;
  bit calm;
  bit hold_req;
  int sent_items;
  int idle_cycles;
  logic [CHAR_W-1:0] term_b [MAX_TERM_DEF];
  logic [CHAR_W-1:0] alpha [3];
  int term_eff;

  weighted_term_frequency_scorer #(
    .MAX_TERM(MAX_TERM_DEF),
    .SCORE_BITS(SCORE_W)
  ) u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_character(in_character),
    .in_field_kind(in_field_kind),
    .in_string_end(in_string_end),
    .in_page_end(in_page_end),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_page_score(out_page_score),
    .out_score_saturated(out_score_saturated),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #(HALF_PERIOD) clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) tracker.check_score(out_page_score, out_score_saturated);
      if (in_valid && in_ready)
        tracker.note_byte(in_character, field_kind_t'(in_field_kind), in_string_end,
                          in_page_end);
      if (cfg_valid && cfg_ready) tracker.apply_reg(cfg_index, cfg_data);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    wait (idle_cycles >= STALL_LIMIT);
    $display("weighted_term_frequency_scorer verification failed");
    $finish;
  end

  function automatic int pick_gap();
    return calm ? 0 : $urandom_range(0, 4);
  endfunction

  function automatic logic [7:0] pick_weight();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [63:0] over_junk(logic [63:0] value, int keep);
    logic [63:0] mask;
    mask = (64'd1 << keep) - 64'd1;
    return ({$urandom, $urandom} & ~mask) | (value & mask);
  endfunction

  // The receiver takes scores with random stalls and, on request, one long hold-off.
  initial begin
    int stall;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      stall = pick_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  task automatic send_char(logic [CHAR_W-1:0] ch, field_kind_t kind, logic str_end,
                           logic pg_end);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_character <= ch;
    in_field_kind <= kind;
    in_string_end <= str_end;
    in_page_end <= pg_end;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    sent_items++;
  endtask

  task automatic send_text(string s, field_kind_t kind, bit pg_end);
    for (int i = 0; i < s.len(); i++)
      send_char(s[i], kind, i == s.len() - 1, pg_end && i == s.len() - 1);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic configure_random();
    logic [2*CFG_DATA_W-1:0] term_bits;
    int len_pick;
    logic [TERM_LEN_W-1:0] len;
    foreach (alpha[i]) alpha[i] = 8'($urandom);
    for (int i = 0; i < MAX_TERM_DEF; i++) begin
      term_b[i] = ($urandom_range(0, 4) == 0) ? 8'($urandom) : alpha[$urandom_range(0, 2)];
      term_bits[8*i +: 8] = term_b[i];
    end
    len_pick = $urandom_range(0, 19);
    if (len_pick == 0) len = 5'd0;
    else if (len_pick == 1) len = 5'($urandom_range(17, 31));
    else if (len_pick < 4) len = 5'd16;
    else len = 5'($urandom_range(1, 6));
    term_eff = (len > MAX_TERM_DEF) ? MAX_TERM_DEF : int'(len);
    write_reg(CFG_TERM_LO, term_bits[63:0]);
    write_reg(CFG_TERM_HI, term_bits[127:64]);
    write_reg(CFG_TERM_LEN, over_junk({59'd0, len}, TERM_LEN_W));
    write_reg(CFG_W_TITLE, over_junk({56'd0, pick_weight()}, WEIGHT_W));
    write_reg(CFG_W_DOMAIN, over_junk({56'd0, pick_weight()}, WEIGHT_W));
    write_reg(CFG_W_KEYWORD, over_junk({56'd0, pick_weight()}, WEIGHT_W));
    write_reg(CFG_W_URL, over_junk({56'd0, pick_weight()}, WEIGHT_W));
    write_reg(CFG_W_TEXT, over_junk({56'd0, pick_weight()}, WEIGHT_W));
    if ($urandom_range(0, 3) == 0) write_reg(CFG_SPARE_IDX, {$urandom, $urandom});
  endtask

  // Strings are mostly built from copies and prefixes of the term and its alphabet.
  task automatic send_string(field_kind_t kind, bit last_of_page);
    logic [CHAR_W-1:0] bytes_q [$];
    int n;
    int plen;
    bit last;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 48) : $urandom_range(1, 16);
    while (bytes_q.size() < n) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          for (int k = 0; k < (term_eff > 0 ? term_eff : 1); k++)
            bytes_q.insert(bytes_q.size(), term_b[k]);
        end
        4, 5: begin
          plen = $urandom_range(1, term_eff > 1 ? term_eff - 1 : 1);
          for (int k = 0; k < plen; k++) bytes_q.insert(bytes_q.size(), term_b[k]);
        end
        6, 7, 8: bytes_q.insert(bytes_q.size(), alpha[$urandom_range(0, 2)]);
        default: bytes_q.insert(bytes_q.size(), 8'($urandom));
      endcase
    end
    for (int i = 0; i < bytes_q.size(); i++) begin
      last = (i == bytes_q.size() - 1);
      send_char(bytes_q[i],
                ($urandom_range(0, 9) == 0) ? field_kind_t'($urandom_range(0, 3)) : kind,
                last && (!last_of_page || $urandom_range(0, 1) == 1),
                last && last_of_page);
    end
  endtask

  task automatic send_page();
    int nstr;
    nstr = $urandom_range(1, 5);
    for (int s = 0; s < nstr; s++)
      send_string(field_kind_t'($urandom_range(0, 3)), s == nstr - 1);
  endtask

  initial begin
    logic [CHAR_W-1:0] sat_byte;
    int phase;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_character = '0;
    in_field_kind = '0;
    in_string_end = 1'b0;
    in_page_end = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    calm = 1'b0;
    hold_req = 1'b0;
    sent_items = 0;
    term_eff = 1;
    tracker = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // With the reset registers the term is a single zero byte.
    send_char(8'h00, KIND_TITLE, 1'b1, 1'b0);
    send_char(8'hFF, KIND_TEXT, 1'b0, 1'b0);
    send_char(8'h00, KIND_URL, 1'b1, 1'b1);
    settle();

    write_reg(CFG_TERM_LO, 64'hA5C3_0FF0_9C61_6261);
    write_reg(CFG_TERM_HI, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(CFG_TERM_LEN, 64'hFFFF_FFFF_FFFF_FFE3);
    write_reg(CFG_W_TITLE, 64'hDEAD_BEEF_0000_01FF);
    write_reg(CFG_W_DOMAIN, 64'h0);
    write_reg(CFG_W_KEYWORD, 64'h7);
    write_reg(CFG_W_URL, 64'hFF);
    write_reg(CFG_W_TEXT, 64'hFFFF_FFFF_FFFF_FF00);
    write_reg(CFG_SPARE_IDX, 64'hFFFF_FFFF_FFFF_FFFF);
    send_text("ababa", KIND_KEYWORD, 1'b0);
    send_text("aaba", KIND_TITLE, 1'b0);
    send_text("ab", KIND_TEXT, 1'b0);
    send_text("a", KIND_TITLE, 1'b0);
    send_char("a", KIND_TITLE, 1'b0, 1'b0);
    send_char("b", KIND_KEYWORD, 1'b0, 1'b0);
    send_char("a", KIND_URL, 1'b1, 1'b1);
    settle();

    write_reg(CFG_TERM_LEN, 64'hFFFF_FFFF_FFFF_FFE0);
    send_text("aba", KIND_TITLE, 1'b1);
    settle();

    phase = 0;
    while (sent_items < STIM_ITEMS || phase < 8) begin
      calm = ($urandom_range(0, 3) == 0);
      configure_random();
      if (phase == 2) begin
        // Hold the score side off so the block backs up and stalls its input.
        hold_req = 1'b1;
        calm = 1'b1;
        repeat (24)
          send_char(alpha[$urandom_range(0, 2)], field_kind_t'($urandom_range(0, 3)),
                    1'b1, 1'b1);
      end else if (phase == 5) begin
        sat_byte = 8'($urandom);
        term_b[0] = sat_byte;
        term_eff = 1;
        write_reg(CFG_TERM_LO, over_junk({56'd0, sat_byte}, CHAR_W));
        write_reg(CFG_TERM_LEN, over_junk(64'd1, TERM_LEN_W));
        write_reg(CFG_W_DOMAIN, 64'hFF);
        write_reg(CFG_W_URL, over_junk(64'hFF, WEIGHT_W));
        for (int i = 0; i <= 140; i++) send_char(sat_byte, KIND_URL, i == 140, i == 140);
      end else begin
        repeat ($urandom_range(1, 4)) send_page();
      end
      settle();
      phase++;
    end

    repeat (8) @(posedge clk);
    if (tracker.pending() != 0)
      tracker.report($sformatf("%0d page scores never arrived", tracker.pending()));
    if (tracker.errors == 0) begin
      $display("weighted_term_frequency_scorer verification clean");
    end else begin
      $display("weighted_term_frequency_scorer verification failed");
    end
    $finish;
  end

endmodule

// ----- weighted_term_frequency_scorer.f -----
design/wtfs_pkg.sv
design/wtfs_cell.sv
design/wtfs_accum.sv
design/weighted_term_frequency_scorer.sv
design/wtfs_checker.sv
sim/tb.sv
